FILE: src/hwd_pkg.sv
package hwd_pkg;

   localparam int NODE_COUNT  = 512;
   localparam int SYMBOL_BITS = 8;
   localparam int BYTE_BITS   = 8;
   localparam int TOP_BIT     = 7;
   localparam int IDX_W       = 9;
   localparam int PAD_W       = 3;
   localparam int ADDR_W      = $clog2(NODE_COUNT);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // A leaf keeps its symbol in the low bits of the right field.
   typedef struct packed {
      logic             leaf;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

   typedef struct packed {
      logic                   is_data;
      logic [IDX_W-1:0]       node_index;
      node_type               node;
      logic [BYTE_BITS-1:0]   data_byte;
      logic                   final_byte;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } walk_state_type;

   function automatic logic index_in_range(input logic [IDX_W-1:0] idx);
      return {1'b0, idx} < (IDX_W + 1)'(NODE_COUNT);
   endfunction

endpackage

FILE: src/hwd_front.sv
module hwd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [hwd_pkg::IDX_W-1:0]     req_node_index,
   input  logic                         req_is_leaf,
   input  logic [hwd_pkg::SYMBOL_BITS-1:0] req_leaf_symbol,
   input  logic [hwd_pkg::IDX_W-1:0]     req_left_child,
   input  logic [hwd_pkg::IDX_W-1:0]     req_right_child,
   input  logic [hwd_pkg::BYTE_BITS-1:0] req_data_byte,
   input  logic                         req_final_byte,
   output logic                         head_valid,
   output hwd_pkg::item_type            head_item,
   input  logic                         head_pop
);
   import hwd_pkg::*;

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;
   logic                  push;
   logic                  pop;
   item_type              new_item;

   always_comb begin
      new_item.is_data    = (req_op == OP_DATA);
      new_item.node_index = req_node_index;
      new_item.node.leaf  = req_is_leaf;
      if (req_is_leaf) begin
         new_item.node.left  = '0;
         new_item.node.right = IDX_W'(req_leaf_symbol);
      end else begin
         new_item.node.left  = req_left_child;
         new_item.node.right = req_right_child;
      end
      new_item.data_byte  = req_data_byte;
      new_item.final_byte = req_final_byte;
   end

   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: src/hwd_back.sv
module hwd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  hwd_pkg::item_type               head_item,
   output logic                            head_pop,
   input  logic [hwd_pkg::PAD_W-1:0]       pad_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hwd_pkg::SYMBOL_BITS-1:0] rsp_symbol,
   output logic                            rsp_last
);
   import hwd_pkg::*;

   node_type                node_mem [NODE_COUNT];
   node_type                rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;

   walk_state_type          state_ff;
   walk_state_type          state_in;
   logic [ADDR_W-1:0]       pos_ff;
   logic [ADDR_W-1:0]       pos_in;
   logic                    arrived_ff;
   logic                    arrived_in;
   node_type                root_ff;
   logic [BYTE_BITS-1:0]    byte_ff;
   logic [BYTE_BITS-1:0]    byte_in;
   logic [PAD_W-1:0]        cnt_ff;
   logic [PAD_W-1:0]        cnt_in;
   logic                    fin_ff;
   logic                    fin_in;
   logic                    hold_valid_ff;
   logic                    hold_valid_in;
   logic [SYMBOL_BITS-1:0]  hold_sym_ff;
   logic [SYMBOL_BITS-1:0]  hold_sym_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SYMBOL_BITS-1:0]  rsp_symbol_ff;
   logic [SYMBOL_BITS-1:0]  rsp_symbol_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   logic                    out_space;
   logic                    emit;
   logic                    stall;
   logic                    finish;
   node_type                eff;
   logic [IDX_W-1:0]        child;
   logic                    child_ok;
   logic                    take_data;

   assign out_space = !rsp_valid_ff || rsp_ready;
   assign emit      = arrived_ff && rd_data_ff.leaf;
   assign eff       = emit ? root_ff : rd_data_ff;
   assign child     = byte_ff[BYTE_BITS-1] ? eff.right : eff.left;
   assign child_ok  = index_in_range(child);
   assign stall     = emit && hold_valid_ff && !out_space;
   assign finish    = !emit && (!hold_valid_ff || out_space);
   assign take_data = head_valid && head_item.is_data;
   assign wr_en     = (state_ff == ST_IDLE) && head_valid && !head_item.is_data
                      && index_in_range(head_item.node_index);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_data) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!stall && cnt_ff == '0) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_pop      = 1'b0;
      pos_in        = pos_ff;
      arrived_in    = arrived_ff;
      byte_in       = byte_ff;
      cnt_in        = cnt_ff;
      fin_in        = fin_ff;
      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            head_pop = head_valid;
            if (take_data) begin
               byte_in       = head_item.data_byte;
               fin_in        = head_item.final_byte;
               cnt_in        = head_item.final_byte ? PAD_W'(TOP_BIT) - pad_bits
                                                    : PAD_W'(TOP_BIT);
               arrived_in    = 1'b0;
               hold_valid_in = 1'b0;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               if (emit) begin
                  hold_valid_in = 1'b1;
                  hold_sym_in   = rd_data_ff.right[SYMBOL_BITS-1:0];
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_symbol_in = hold_sym_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
               if (eff.leaf || !child_ok) begin
                  pos_in     = '0;
                  arrived_in = 1'b0;
               end else begin
                  pos_in     = child[ADDR_W-1:0];
                  arrived_in = 1'b1;
               end
               byte_in = {byte_ff[BYTE_BITS-2:0], 1'b0};
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         ST_FLUSH: begin
            if (emit) begin
               if (!stall) begin
                  hold_valid_in = 1'b1;
                  hold_sym_in   = rd_data_ff.right[SYMBOL_BITS-1:0];
                  pos_in        = '0;
                  arrived_in    = 1'b0;
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_symbol_in = hold_sym_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
            end else if (finish) begin
               if (hold_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = hold_sym_ff;
                  rsp_last_in   = 1'b1;
               end
               hold_valid_in = 1'b0;
               arrived_in    = 1'b0;
               if (fin_ff) begin
                  pos_in = '0;
               end
            end
         end
         default: begin
            head_pop = 1'b0;
         end
      endcase
   end

   // The table is read every cycle at the position the walk moves to, so the
   // registered read data holds the node at the current position; a load to that entry shows from the next read on.
   assign rd_addr = pos_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[head_item.node_index[ADDR_W-1:0]] <= head_item.node;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && head_item.node_index == '0) begin
         root_ff <= head_item.node;
      end
      byte_ff       <= byte_in;
      cnt_ff        <= cnt_in;
      fin_ff        <= fin_in;
      hold_sym_ff   <= hold_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         arrived_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         arrived_ff    <= arrived_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: src/huffman_tree_walk_decoder.sv
// Huffman decoder that walks a code tree stored in an on-chip node table.
// The request channel carries two kinds of transfer: a load writes one node
// of the table (root at node zero), and a data transfer brings one
// compressed byte that is decoded MSB first. Each decoded symbol leaves as
// one transfer on the response channel, and the last symbol of a byte is
// marked with rsp_last. A byte may produce no symbol at all.
// The csr port writes the number of pad bits dropped from the final byte.
// Requests enter a two-entry queue, so the sender keeps moving while the
// walker is busy. A load is written to the node table in the idle state. A
// data byte is started in the idle state, walked one used bit per cycle
// while the output does not stall, and finished in a flush state; this pace
// is set by the one dependent node-table read that each bit needs.
// Each symbol waits in the walker until the next one or the end of its byte
// is known.
// When the receiver stalls, the walker waits on the output register and the
// queue fills, after which req_ready drops.
// Reset returns the walk to the root, clears pad_bits and empties the queue
// and output; the node table keeps whatever it held and must be loaded.
module huffman_tree_walk_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [hwd_pkg::IDX_W-1:0]       req_node_index,
   input  logic                            req_is_leaf,
   input  logic [hwd_pkg::SYMBOL_BITS-1:0] req_leaf_symbol,
   input  logic [hwd_pkg::IDX_W-1:0]       req_left_child,
   input  logic [hwd_pkg::IDX_W-1:0]       req_right_child,
   input  logic [hwd_pkg::BYTE_BITS-1:0]   req_data_byte,
   input  logic                            req_final_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hwd_pkg::SYMBOL_BITS-1:0] rsp_symbol,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [hwd_pkg::PAD_W-1:0]       csr_wr_data
);
   import hwd_pkg::*;

   logic [PAD_W-1:0] pad_bits_ff;
   logic [PAD_W-1:0] pad_bits_in;
   logic             head_valid;
   item_type         head_item;
   logic             head_pop;

   assign pad_bits_in = csr_wr_en ? csr_wr_data : pad_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_bits_ff <= '0;
      end else begin
         pad_bits_ff <= pad_bits_in;
      end
   end

   hwd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_node_index  (req_node_index),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop)
   );

   hwd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .pad_bits   (pad_bits_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

FILE: verif/huffman_symbol_check.sv
module huffman_symbol_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_op,
   input  logic [hwd_pkg::IDX_W-1:0]       req_node_index,
   input  logic                            req_is_leaf,
   input  logic [hwd_pkg::SYMBOL_BITS-1:0] req_leaf_symbol,
   input  logic [hwd_pkg::IDX_W-1:0]       req_left_child,
   input  logic [hwd_pkg::IDX_W-1:0]       req_right_child,
   input  logic [hwd_pkg::BYTE_BITS-1:0]   req_data_byte,
   input  logic                            req_final_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [hwd_pkg::SYMBOL_BITS-1:0] rsp_symbol,
   input  logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [hwd_pkg::PAD_W-1:0]       csr_wr_data,
   output int                              fail_count,
   output int                              owed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import hwd_pkg::*;

   typedef struct {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   last;
   } decoded_type;

   node_type         tree_nodes [NODE_COUNT];
   logic [IDX_W-1:0] walk_node;
   logic [PAD_W-1:0] pad_bits;
   decoded_type      symbol_queue [$];

   // Walks the code tree for one compressed byte and queues every symbol it yields.
   task automatic decode_byte(input logic [BYTE_BITS-1:0] data_in, input logic fin);
      int          used_bits;
      int          produced;
      logic        bit_val;
      node_type    cur;
      node_type    nxt;
      logic [IDX_W-1:0] child;
      decoded_type found;
      used_bits = fin ? BYTE_BITS - int'(pad_bits) : BYTE_BITS;
      produced = 0;
      for (int k = 0; k < used_bits; k++) begin
         bit_val = data_in[TOP_BIT - k];
         cur = tree_nodes[walk_node];
         if (cur.leaf) begin
            walk_node = '0;
         end else begin
            child = bit_val ? cur.right : cur.left;
            if (int'(child) >= NODE_COUNT) begin
               walk_node = '0;
            end else begin
               nxt = tree_nodes[child];
               if (nxt.leaf) begin
                  found.symbol = nxt.right[SYMBOL_BITS-1:0];
                  found.last = 1'b0;
                  symbol_queue.push_back(found);
                  produced++;
                  walk_node = '0;
               end else begin
                  walk_node = child;
               end
            end
         end
      end
      if (fin) begin
         walk_node = '0;
      end
      if (produced > 0) begin
         symbol_queue[symbol_queue.size() - 1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin : track
      decoded_type head;
      if (reset) begin
         walk_node = '0;
         pad_bits = '0;
         symbol_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (symbol_queue.size() == 0) begin
               $display("%0t: symbol %02h last %0b arrived, none expected",
                        $time, rsp_symbol, rsp_last);
               fail_count++;
            end else begin
               head = symbol_queue.pop_front();
               if (rsp_symbol !== head.symbol) begin
                  $display("%0t: symbol expected %02h got %02h",
                           $time, head.symbol, rsp_symbol);
                  fail_count++;
               end
               if (rsp_last !== head.last) begin
                  $display("%0t: last expected %0b got %0b", $time, head.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            pad_bits = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               if (int'(req_node_index) < NODE_COUNT) begin
                  if (req_is_leaf) begin
                     tree_nodes[req_node_index] = '{leaf: 1'b1, left: '0,
                                                    right: IDX_W'(req_leaf_symbol)};
                  end else begin
                     tree_nodes[req_node_index] = '{leaf: 1'b0, left: req_left_child,
                                                    right: req_right_child};
                  end
               end
            end else begin
               decode_byte(req_data_byte, req_final_byte);
            end
         end
      end
      owed_count = symbol_queue.size();
   end

endmodule

FILE: verif/huffman_tree_walk_decoder_tb.sv
module huffman_tree_walk_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hwd_pkg::*;

   localparam int RANDOM_ITEMS  = 300;
   localparam int SETTLE_CYCLES = 60;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_op;
   logic [IDX_W-1:0]       req_node_index;
   logic                   req_is_leaf;
   logic [SYMBOL_BITS-1:0] req_leaf_symbol;
   logic [IDX_W-1:0]       req_left_child;
   logic [IDX_W-1:0]       req_right_child;
   logic [BYTE_BITS-1:0]   req_data_byte;
   logic                   req_final_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [SYMBOL_BITS-1:0] rsp_symbol;
   logic                   rsp_last;
   logic                   csr_wr_en;
   logic [PAD_W-1:0]       csr_wr_data;
   int                     fail_count;
   int                     owed_count;

   logic             req_steady = 1'b0;
   logic             rsp_steady = 1'b0;
   int               sent_items = 0;
   logic [IDX_W-1:0] members [$];

   huffman_tree_walk_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_node_index  (req_node_index),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   huffman_symbol_check symbol_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_node_index  (req_node_index),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .owed_count      (owed_count)
   );

   always #10 clock = ~clock;

   task automatic push_request(input logic op, input logic [IDX_W-1:0] idx,
                               input logic leaf, input logic [SYMBOL_BITS-1:0] sym,
                               input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                               input logic [BYTE_BITS-1:0] data_in, input logic fin);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op = op;
      req_node_index = idx;
      req_is_leaf = leaf;
      req_leaf_symbol = sym;
      req_left_child = lc;
      req_right_child = rc;
      req_data_byte = data_in;
      req_final_byte = fin;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      sent_items++;
      if ($urandom_range(0, 19) == 0) begin
         req_steady = !req_steady;
      end
   endtask

   task automatic load_leaf(input logic [IDX_W-1:0] idx, input logic [SYMBOL_BITS-1:0] sym);
      push_request(OP_LOAD, idx, 1'b1, sym, IDX_W'($urandom), IDX_W'($urandom),
                   BYTE_BITS'($urandom), 1'($urandom));
   endtask

   task automatic load_inner(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lc,
                             input logic [IDX_W-1:0] rc);
      push_request(OP_LOAD, idx, 1'b0, SYMBOL_BITS'($urandom), lc, rc,
                   BYTE_BITS'($urandom), 1'($urandom));
   endtask

   task automatic feed_byte(input logic [BYTE_BITS-1:0] data_in, input logic fin);
      push_request(OP_DATA, IDX_W'($urandom), 1'($urandom), SYMBOL_BITS'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom), data_in, fin);
   endtask

   // The pad register may only change once the walker has finished all earlier bytes.
   task automatic set_pad(input logic [PAD_W-1:0] pad);
      while (owed_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_data = pad;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [IDX_W-1:0] fresh_index();
      logic [IDX_W-1:0] cand;
      logic             taken;
      do begin
         cand = IDX_W'($urandom_range(1, NODE_COUNT - 1));
         taken = 1'b0;
         foreach (members[m]) begin
            if (members[m] == cand) begin
               taken = 1'b1;
            end
         end
      end while (taken);
      members.push_back(cand);
      return cand;
   endfunction

   initial begin
      int               rsp_wait;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_wait = rsp_steady ? 0 : $urandom_range(0, 14);
         if (rsp_wait > 0) begin
            rsp_ready = 1'b0;
            repeat (rsp_wait) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         if ($urandom_range(0, 24) == 0) begin
            rsp_steady = !rsp_steady;
         end
      end
   end

   initial begin
      int               directed_items;
      int               phase;
      int               leaves;
      int               pick;
      int               sel;
      logic [IDX_W-1:0] pool [$];
      logic [IDX_W-1:0] sub_a;
      logic [IDX_W-1:0] sub_b;
      logic [IDX_W-1:0] fresh;
      logic [PAD_W-1:0] phase_pad;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_LOAD;
      req_node_index = '0;
      req_is_leaf = 1'b0;
      req_leaf_symbol = '0;
      req_left_child = '0;
      req_right_child = '0;
      req_data_byte = '0;
      req_final_byte = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_pad(3'd0);
      load_leaf(9'd1, 8'h00);
      load_leaf(9'd3, 8'hFF);
      load_leaf(9'd5, 8'hA5);
      load_leaf(9'd511, 8'h5A);
      load_inner(9'd4, 9'd5, 9'd511);
      load_inner(9'd2, 9'd3, 9'd4);
      load_inner(9'd0, 9'd1, 9'd2);
      feed_byte(8'h00, 1'b0);
      feed_byte(8'hFF, 1'b0);
      feed_byte(8'h3F, 1'b0);
      feed_byte(8'hC0, 1'b1);
      // The walk stops on node 4, which then turns into a leaf under it.
      feed_byte(8'hFF, 1'b0);
      load_leaf(9'd4, 8'h77);
      feed_byte(8'h00, 1'b0);
      load_inner(9'd4, 9'd5, 9'd511);
      // A tree made of a single leaf at the root decodes to nothing.
      load_leaf(9'd0, 8'h42);
      feed_byte(8'hA5, 1'b0);
      feed_byte(8'h00, 1'b1);
      load_inner(9'd0, 9'd1, 9'd2);
      feed_byte(8'hFF, 1'b1);
      set_pad(3'd7);
      feed_byte(8'h80, 1'b1);
      feed_byte(8'h7F, 1'b1);
      feed_byte(8'h00, 1'b0);
      feed_byte(8'hFF, 1'b1);
      directed_items = sent_items;

      phase = 0;
      while (sent_items < directed_items + RANDOM_ITEMS) begin
         if (phase % 4 == 0) begin
            phase_pad = 3'd0;
         end else if (phase % 4 == 1) begin
            phase_pad = 3'd7;
         end else begin
            phase_pad = PAD_W'($urandom_range(0, 7));
         end
         set_pad(phase_pad);

         // Leaves go in first and every inner node after its children, so no walk
         // ever reaches an entry that was never loaded.
         members.delete();
         members.push_back('0);
         pool.delete();
         leaves = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
         if (leaves == 1) begin
            load_leaf('0, SYMBOL_BITS'($urandom));
         end else begin
            repeat (leaves) begin
               fresh = fresh_index();
               load_leaf(fresh, SYMBOL_BITS'($urandom));
               pool.push_back(fresh);
            end
            while (pool.size() > 2) begin
               pick = $urandom_range(0, pool.size() - 1);
               sub_a = pool[pick];
               pool.delete(pick);
               pick = $urandom_range(0, pool.size() - 1);
               sub_b = pool[pick];
               pool.delete(pick);
               fresh = fresh_index();
               load_inner(fresh, sub_a, sub_b);
               pool.push_back(fresh);
            end
            load_inner('0, pool[0], pool[1]);
         end

         repeat ($urandom_range(20, 45)) begin
            sel = $urandom_range(0, 19);
            if (sel < 17) begin
               feed_byte(BYTE_BITS'($urandom), $urandom_range(0, 4) == 0);
            end else if (sel == 17) begin
               load_leaf(members[$urandom_range(0, members.size() - 1)],
                         SYMBOL_BITS'($urandom));
            end else if (sel == 18) begin
               load_inner(members[$urandom_range(0, members.size() - 1)],
                          members[$urandom_range(0, members.size() - 1)],
                          members[$urandom_range(0, members.size() - 1)]);
            end else begin
               load_inner(IDX_W'($urandom),
                          members[$urandom_range(0, members.size() - 1)],
                          members[$urandom_range(0, members.size() - 1)]);
            end
         end
         phase++;
      end

      req_valid = 1'b0;
      while (owed_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("huffman_tree_walk_decoder_tb OK");
      end else begin
         $display("huffman_tree_walk_decoder_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("huffman_tree_walk_decoder_tb NOT OK");
      $finish;
   end

endmodule
